@@ hw/rtl/icgt_pkg.sv @@
`timescale 1ns / 1ps
package icgt_pkg;

  localparam int DEF_TABLE_DEPTH = 64;
  localparam int DEF_KEY_BITS    = 32;

  localparam logic       ACT_INSERT = 1'b0;
  localparam logic       ACT_EMIT   = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        action;
    logic [31:0] range_low;
    logic [31:0] range_high;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] gap_low;
    logic [31:0] gap_high;
    logic        gap_valid;
    logic        last;
  } rsp_word_t;

endpackage

@@ hw/rtl/interval_coverage_gap_table.sv @@
`timescale 1ns / 1ps
// Interval coverage gap table.
// Request channel (req, req_valid, req_stall): one word per command. An insert
// marks range_low..range_high covered; an emit reports every uncovered gap in
// ascending order and then clears the table.
// Response channel (rsp, rsp_valid, rsp_stall): an insert gives one word with
// its status; an emit gives one word per gap, last set on the final one, or a
// single word with gap_valid low when nothing is uncovered.
// The table lives in two ping-pong memories. An insert streams the active bank
// into the other one, merging in the new breakpoints. An emit walks the active
// bank. An error is answered without a walk. One command is in flight at a
// time; req_stall is high while it is at work.
// Reset: after rst falls the table is seeded in S_INIT with the all-ones
// breakpoint, uncovered, and the first request is taken the cycle after.
// A stalled response holds in the output register; the walk pauses only when
// a second word is ready before the first has been taken.
module interval_coverage_gap_table
  import icgt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  req_word_t req,
  input  logic      req_valid,
  output logic      req_stall,
  output rsp_word_t rsp,
  output logic      rsp_valid,
  input  logic      rsp_stall
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = KEY_BITS + 1;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_RD   = 7'b0000100,
    S_MRG  = 7'b0001000,
    S_ERD  = 7'b0010000,
    S_EGAP = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                state, state_next;
  logic                  sel, emit_mode;
  logic [CW-1:0]         count, idx, wptr;
  logic [KEY_BITS-1:0]   lo, hi, k1, k2, start, plo, phi;
  logic                  k1v, k2v, pv;
  logic [1:0]            stat;

  logic [KEY_BITS-1:0]   req_lo, req_hi, cur_key;
  logic                  cur_flag;
  logic                  ov_can, emit;
  rsp_word_t             emit_word;
  logic                  we, wbank, re;
  logic [AW-1:0]         waddr;
  logic [EW-1:0]         wdata, rdata0, rdata1, rdata;

  assign req_lo   = KEY_BITS'(req.range_low);
  assign req_hi   = KEY_BITS'(req.range_high);
  assign rdata    = sel ? rdata1 : rdata0;
  assign cur_key  = rdata[EW-1:1];
  assign cur_flag = rdata[0];
  assign ov_can   = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  function automatic logic in_range(input logic [KEY_BITS-1:0] k,
                                    input logic [KEY_BITS-1:0] l,
                                    input logic [KEY_BITS-1:0] h);
    in_range = (k >= l) && (k <= h);
  endfunction

  icgt_bank #(.DEPTH(TABLE_DEPTH), .WIDTH(EW), .AW(AW)) u_bank0 (
    .clk, .we(we && !wbank), .waddr, .wdata, .re(re && !sel),
    .raddr(idx[AW-1:0]), .rdata(rdata0)
  );

  icgt_bank #(.DEPTH(TABLE_DEPTH), .WIDTH(EW), .AW(AW)) u_bank1 (
    .clk, .we(we && wbank), .waddr, .wdata, .re(re && sel),
    .raddr(idx[AW-1:0]), .rdata(rdata1)
  );

  always_comb begin
    state_next = state;
    we         = 1'b0;
    wbank      = !sel;
    waddr      = wptr[AW-1:0];
    wdata      = {cur_key, cur_flag | in_range(cur_key, lo, hi)};
    re         = 1'b0;
    emit       = 1'b0;
    emit_word  = '0;
    case (state)
      S_INIT: begin
        we         = 1'b1;
        wbank      = sel;
        waddr      = '0;
        wdata      = {{KEY_BITS{1'b1}}, 1'b0};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          if (req.action == ACT_EMIT) begin
            state_next = S_ERD;
          end else if (req_lo > req_hi || count > CW'(TABLE_DEPTH - 2)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD, S_ERD: begin
        re         = 1'b1;
        state_next = (state == S_RD) ? S_MRG : S_EGAP;
      end
      S_MRG: begin
        if (k1v && k1 <= cur_key) begin
          we    = (k1 != cur_key);
          wdata = {k1, cur_flag | in_range(k1, lo, hi)};
        end else if (k2v && k2 <= cur_key) begin
          we    = (k2 != cur_key);
          wdata = {k2, cur_flag | in_range(k2, lo, hi)};
        end else begin
          we         = 1'b1;
          state_next = (idx == count - CW'(1)) ? S_DONE : S_RD;
        end
      end
      S_EGAP: begin
        if (!(!cur_flag && pv && !ov_can)) begin
          if (!cur_flag && pv) begin
            emit      = 1'b1;
            emit_word = '{status: ST_OK, gap_low: 32'(plo), gap_high: 32'(phi),
                          gap_valid: 1'b1, last: 1'b0};
          end
          state_next = (idx == count - CW'(1)) ? S_DONE : S_ERD;
        end
      end
      S_DONE: begin
        if (ov_can) begin
          emit = 1'b1;
          if (emit_mode) begin
            we        = 1'b1;
            wbank     = sel;
            waddr     = '0;
            wdata     = {{KEY_BITS{1'b1}}, 1'b0};
            emit_word = '{status: ST_OK, gap_low: pv ? 32'(plo) : 32'd0,
                          gap_high: pv ? 32'(phi) : 32'd0, gap_valid: pv,
                          last: 1'b1};
          end else begin
            emit_word = '{status: stat, gap_low: 32'd0, gap_high: 32'd0,
                          gap_valid: 1'b0, last: 1'b1};
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sel       <= 1'b0;
      count     <= CW'(1);
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (state == S_MRG && state_next == S_DONE) begin
        sel   <= !sel;
        count <= wptr + CW'(1);
      end
      if (state == S_DONE && emit_mode && ov_can) begin
        count <= CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp <= emit_word;
    end
    case (state)
      S_IDLE: begin
        lo        <= req_lo;
        hi        <= req_hi;
        k1        <= req_lo - KEY_BITS'(1);
        k1v       <= (req_lo != '0);
        k2        <= req_hi;
        k2v       <= 1'b1;
        idx       <= '0;
        wptr      <= '0;
        start     <= '0;
        pv        <= 1'b0;
        emit_mode <= (req.action == ACT_EMIT);
        stat      <= (req_lo > req_hi) ? ST_ORDER :
                     (count > CW'(TABLE_DEPTH - 2)) ? ST_FULL : ST_OK;
      end
      S_MRG: begin
        if (k1v && k1 <= cur_key) begin
          k1v <= 1'b0;
          if (k1 != cur_key) wptr <= wptr + CW'(1);
        end else if (k2v && k2 <= cur_key) begin
          k2v <= 1'b0;
          if (k2 != cur_key) wptr <= wptr + CW'(1);
        end else begin
          wptr <= wptr + CW'(1);
          idx  <= idx + CW'(1);
        end
      end
      S_EGAP: begin
        if (!(!cur_flag && pv && !ov_can)) begin
          if (!cur_flag) begin
            pv  <= 1'b1;
            plo <= start;
            phi <= cur_key;
          end
          start <= cur_key + KEY_BITS'(1);
          idx   <= idx + CW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/icgt_bank.sv @@
`timescale 1ns / 1ps
module icgt_bank #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/icgt_chk.sv @@
`timescale 1ns / 1ps
module icgt_chk
  import icgt_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input rsp_word_t rsp,
  input logic      rsp_valid,
  input logic      rsp_stall
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response word changed");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.last && !rsp.gap_valid)
    else $error("error word not final or carries a gap");

  a_gap_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.gap_valid |-> rsp.gap_low <= rsp.gap_high)
    else $error("gap bounds out of order");

  a_nogap_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.gap_valid |-> rsp.last)
    else $error("word without gap is not final");

endmodule

bind interval_coverage_gap_table icgt_chk u_icgt_chk (
  .clk(clk), .rst(rst), .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
);

@@ test/interval_coverage_gap_table_test.sv @@
`timescale 1ns / 1ps
module interval_coverage_gap_table_test;
  import icgt_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam longint CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  req_word_t req = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  rsp_word_t rsp;
  logic rsp_valid;
  logic rsp_stall = 1'b0;

  interval_coverage_gap_table dut (
    .clk(clk), .rst(rst),
    .req(req), .req_valid(req_valid), .req_stall(req_stall),
    .rsp(rsp), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall)
  );

  always #2 clk = ~clk;

  // predicted table
  logic [31:0] bp_key [DEPTH];
  bit bp_covered [DEPTH];
  int bp_count;

  req_word_t command_queue[$];
  rsp_word_t gap_words[$];
  int send_idle = 0;
  int recv_idle = 0;
  bit long_hold = 1'b0;
  int mismatches = 0;
  int commands_taken = 0;
  int words_seen = 0;
  int gaps_seen = 0;
  int full_seen = 0;
  int order_seen = 0;
  longint cycles = 0;

  function automatic void table_reset();
    for (int i = 0; i < DEPTH; i++) begin
      bp_key[i] = '0;
      bp_covered[i] = 1'b0;
    end
    bp_key[0] = '1;
    bp_count = 1;
  endfunction

  function automatic int slot_of(logic [31:0] k);
    for (int i = 0; i < bp_count; i++) begin
      if (bp_key[i] >= k) return i;
    end
    return bp_count - 1;
  endfunction

  function automatic void split_at(logic [31:0] k);
    int pos;
    pos = slot_of(k);
    if (bp_key[pos] == k || bp_count >= DEPTH) return;
    for (int i = bp_count; i > pos; i--) begin
      bp_key[i] = bp_key[i - 1];
      bp_covered[i] = bp_covered[i - 1];
    end
    bp_key[pos] = k;
    bp_count++;
  endfunction

  function automatic void predict_gaps(req_word_t w);
    rsp_word_t r;
    logic [31:0] start;
    int a;
    int b;
    int n;
    r = '0;
    r.last = 1'b1;
    if (w.action == ACT_INSERT) begin
      if (w.range_low > w.range_high) begin
        r.status = ST_ORDER;
      end else if (DEPTH - bp_count < 2) begin
        r.status = ST_FULL;
      end else begin
        if (w.range_low != 0) split_at(w.range_low - 1);
        split_at(w.range_high);
        a = slot_of(w.range_low);
        b = slot_of(w.range_high);
        for (int i = a; i <= b; i++) bp_covered[i] = 1'b1;
        r.status = ST_OK;
      end
      gap_words.push_back(r);
    end else begin
      n = 0;
      start = '0;
      for (int i = 0; i < bp_count; i++) begin
        if (!bp_covered[i]) begin
          r = '0;
          r.status = ST_OK;
          r.gap_low = start;
          r.gap_high = bp_key[i];
          r.gap_valid = 1'b1;
          gap_words.push_back(r);
          n++;
        end
        start = bp_key[i] + 1;
      end
      if (n == 0) begin
        r = '0;
        r.last = 1'b1;
        gap_words.push_back(r);
      end else begin
        gap_words[gap_words.size() - 1].last = 1'b1;
      end
      table_reset();
    end
  endfunction

  function automatic req_word_t cmd(logic act, logic [31:0] lo, logic [31:0] hi);
    req_word_t w;
    w.action = act;
    w.range_low = lo;
    w.range_high = hi;
    return w;
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 64);
      1: return 32'hffff_ffff - $urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_range();
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] t;
    lo = pick_key();
    hi = ($urandom_range(0, 2) == 0) ? lo + $urandom_range(0, 8) : pick_key();
    if (lo > hi && $urandom_range(0, 9) != 0) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    command_queue.push_back(cmd(ACT_INSERT, lo, hi));
  endtask

  // insert random and strided range sequences, each closed by an emit
  task automatic run_sequences(int target);
    int made;
    int n;
    logic [31:0] base;
    logic [31:0] step;
    made = 0;
    while (made < target) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(30, 36);
        base = $urandom_range(0, 1000);
        step = $urandom_range(3, 40);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 9) == 0) add_range();
          else command_queue.push_back(cmd(ACT_INSERT, base + i * step + 1,
                                           base + i * step + 1 + $urandom_range(0, step - 3)));
        end
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) add_range();
      end
      command_queue.push_back(cmd(ACT_EMIT, $urandom, $urandom));
      made += n + 1;
    end
  endtask

  task automatic drain();
    while (command_queue.size() != 0 || req_valid || gap_words.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_gaps(req);
        commands_taken++;
      end
      if (!req_valid || !req_stall) begin
        if (command_queue.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          req <= command_queue.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    rsp_word_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      words_seen++;
      if (rsp.gap_valid) gaps_seen++;
      if (rsp.status == ST_FULL) full_seen++;
      if (rsp.status == ST_ORDER) order_seen++;
      if (gap_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", rsp);
      end else begin
        e = gap_words.pop_front();
        if (rsp.status !== e.status || rsp.gap_low !== e.gap_low ||
            rsp.gap_high !== e.gap_high || rsp.gap_valid !== e.gap_valid ||
            rsp.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d %h..%h v=%b l=%b, got st=%0d %h..%h v=%b l=%b",
                     e.status, e.gap_low, e.gap_high, e.gap_valid, e.last,
                     rsp.status, rsp.gap_low, rsp.gap_high, rsp.gap_valid, rsp.last);
        end
      end
    end
    rsp_stall <= long_hold || ($urandom_range(0, 99) < recv_idle);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("interval_coverage_gap_table_test: done, errors");
      $finish;
    end
  end

  // hold the response side off while commands keep coming
  initial begin
    wait (commands_taken >= 5);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (1500) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    table_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    command_queue.push_back(cmd(ACT_EMIT, 0, 0));
    command_queue.push_back(cmd(ACT_INSERT, 0, 32'hffff_ffff));
    command_queue.push_back(cmd(ACT_EMIT, 0, 0));
    command_queue.push_back(cmd(ACT_INSERT, 5, 3));
    command_queue.push_back(cmd(ACT_INSERT, 32'hffff_ffff, 0));
    command_queue.push_back(cmd(ACT_INSERT, 0, 0));
    command_queue.push_back(cmd(ACT_INSERT, 32'hffff_ffff, 32'hffff_ffff));
    command_queue.push_back(cmd(ACT_INSERT, 10, 20));
    command_queue.push_back(cmd(ACT_INSERT, 15, 30));
    command_queue.push_back(cmd(ACT_INSERT, 21, 21));
    command_queue.push_back(cmd(ACT_INSERT, 32'h8000_0000, 32'hffff_fffe));
    command_queue.push_back(cmd(ACT_EMIT, 32'hffff_ffff, 32'hffff_ffff));
    command_queue.push_back(cmd(ACT_INSERT, 1, 1));
    command_queue.push_back(cmd(ACT_INSERT, 3, 3));
    command_queue.push_back(cmd(ACT_INSERT, 2, 2));
    command_queue.push_back(cmd(ACT_EMIT, 0, 0));
    command_queue.push_back(cmd(ACT_INSERT, 32'h7fff_ffff, 32'h8000_0000));
    command_queue.push_back(cmd(ACT_EMIT, 0, 0));
    run_sequences(25);
    drain();

    send_idle = 81;
    run_sequences(25);
    drain();

    send_idle = 0;
    recv_idle = 81;
    run_sequences(25);
    drain();

    send_idle = 32;
    recv_idle = 32;
    run_sequences(25);
    drain();

    repeat (200) @(posedge clk);
    $display("covered %0d commands, %0d words (%0d gaps, %0d table full, %0d low above high)",
             commands_taken, words_seen, gaps_seen, full_seen, order_seen);
    $display("idle mixes: none, sender, receiver, both; mismatches %0d", mismatches);
    if (mismatches == 0 && gap_words.size() == 0) begin
      $display("interval_coverage_gap_table_test: done, clean");
    end else begin
      $display("interval_coverage_gap_table_test: done, errors");
    end
    $finish;
  end

endmodule
